// ----- design/mtd_pkg.sv -----
package mtd_pkg;

    localparam int SORTERS_DEF    = 4;
    localparam int COORD_BITS_DEF = 12;

    // sorter bits carried by the input word
    localparam int IN_BITS = 4;

    localparam int FW_W    = 16;
    localparam int FH_W    = 16;
    localparam int EDGE_W  = 9;
    localparam int TOTAL_W = 25;
    localparam int TILE_W  = 24;
    localparam int SIDX_W  = 2;
    localparam int GRID_W  = 16;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;

    // grid divide: (dim + edge - 1) / edge
    localparam int NUM_W = FW_W + 1;
    localparam int DEN_W = EDGE_W;

    localparam logic [FW_W-1:0]    FRAME_WIDTH_RST  = FW_W'(1920);
    localparam logic [FH_W-1:0]    FRAME_HEIGHT_RST = FH_W'(1080);
    localparam logic [EDGE_W-1:0]  TILE_EDGE_RST    = EDGE_W'(16);
    localparam logic [TOTAL_W-1:0] TOTAL_TILES_RST  = '0;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_EDGE    = 2'd2;
    localparam logic [1:0] REG_TOTAL_TILES  = 2'd3;

    localparam logic KIND_ASSIGN = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic ACTION_TICK  = 1'b0;
    localparam logic ACTION_START = 1'b1;

    typedef struct packed {
        logic [FW_W-1:0]    frame_width;
        logic [FH_W-1:0]    frame_height;
        logic [EDGE_W-1:0]  tile_edge;
        logic [TOTAL_W-1:0] total_tiles;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic [SIDX_W-1:0] sorter_index;
        logic [TILE_W-1:0] tile_index;
        logic              phase_busy;
        logic              last;
    } out_word_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVW_GO,
        S_DIVW_RUN,
        S_DIVH_GO,
        S_DIVH_RUN,
        S_SCAN,
        S_CHECK,
        S_SEARCH,
        S_MUL,
        S_EMIT,
        S_STATUS
    } state_t;

endpackage

// ----- design/mtd_div.sv -----
module mtd_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [mtd_pkg::NUM_W-1:0] numer,
    input  logic [mtd_pkg::DEN_W-1:0] denom,
    output logic                      done,
    output logic [mtd_pkg::NUM_W-1:0] quo
);
    import mtd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [NUM_W-1:0] quo_reg, quo_next;

    logic [DEN_W:0]   trial;
    logic             ge;

    // restoring divide, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign ge    = trial >= {1'b0, denom};

    always_comb
    begin
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            cnt_next = CNT_W'(NUM_W);
            run_next = 1'b1;
            rem_next = '0;
            quo_next = numer;
        end
        else if (run_reg)
        begin
            rem_next = ge ? DEN_W'(trial - {1'b0, denom}) : DEN_W'(trial);
            quo_next = {quo_reg[NUM_W-2:0], ge};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

// ----- design/mtd_core.sv -----
module mtd_core #(
    parameter int SORTERS    = mtd_pkg::SORTERS_DEF,
    parameter int COORD_BITS = mtd_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mtd_pkg::cfg_t                cfg,
    input  logic                         cfg_wr,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         in_action,
    input  logic [mtd_pkg::IN_BITS-1:0]  in_free,
    input  logic [mtd_pkg::IN_BITS-1:0]  in_done,
    output logic                         word_valid,
    input  logic                         word_ready,
    output mtd_pkg::out_word_t           word
);
    import mtd_pkg::*;

    localparam int CODE_BITS = 2 * COORD_BITS;
    localparam int P_W       = $clog2(CODE_BITS);
    localparam int CMP_W     = (COORD_BITS > GRID_W) ? COORD_BITS : GRID_W;
    localparam int PROD_W    = COORD_BITS + GRID_W;
    localparam logic [IN_BITS-1:0] NS_MASK =
        (SORTERS >= IN_BITS) ? {IN_BITS{1'b1}} : IN_BITS'((1 << SORTERS) - 1);

    state_t state_reg, state_next;

    logic                  pending_reg, pending_next;
    logic                  running_reg, running_next;
    logic [TOTAL_W-1:0]    issued_reg, issued_next;
    logic [CODE_BITS-1:0]  counter_reg, counter_next;
    logic                  check_end_reg, check_end_next;
    logic                  all_done_reg, all_done_next;
    logic                  done_ok_reg, done_ok_next;
    logic [IN_BITS-1:0]    free_reg, free_next;
    logic [SIDX_W-1:0]     idx_reg, idx_next;
    logic [P_W-1:0]        p_reg, p_next;
    logic [CODE_BITS-1:0]  code_reg, code_next;
    logic [TILE_W-1:0]     prod_reg, prod_next;
    logic [GRID_W-1:0]     gw_reg, gw_next;
    logic [GRID_W-1:0]     gh_reg, gh_next;

    logic [EDGE_W-1:0]     edge_eff;
    logic [NUM_W-1:0]      div_numer;
    logic [NUM_W-1:0]      div_quo;
    logic                  div_start;
    logic                  div_done;
    logic [GRID_W-1:0]     grid_dim;

    logic [CODE_BITS-1:0]  cand;
    logic [CODE_BITS-1:0]  sel_code;
    logic [COORD_BITS-1:0] coord_x;
    logic [COORD_BITS-1:0] coord_y;
    logic                  grid_hit;
    logic                  p_last;
    logic                  quota_met;
    logic                  end_now;
    logic [PROD_W-1:0]     prod_full;

    assign edge_eff = (cfg.tile_edge == '0) ? EDGE_W'(1) : cfg.tile_edge;

    always_comb
    begin
        if (state_reg == S_DIVW_GO || state_reg == S_DIVW_RUN)
            div_numer = NUM_W'(cfg.frame_width) + NUM_W'(edge_eff) - NUM_W'(1);
        else
            div_numer = NUM_W'(cfg.frame_height) + NUM_W'(edge_eff) - NUM_W'(1);
    end

    mtd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (edge_eff),
        .done  (div_done),
        .quo   (div_quo)
    );

    // empty grid dimension counts as one
    assign grid_dim = (div_quo == '0) ? GRID_W'(1) : div_quo[GRID_W-1:0];

    // candidate: set bit p, clear everything below it
    assign cand = (counter_reg & ({CODE_BITS{1'b1}} << p_reg))
                | (CODE_BITS'(1) << p_reg);

    always_comb
    begin
        unique case (state_reg)
            S_CHECK:  sel_code = counter_reg;
            S_SEARCH: sel_code = cand;
            default:  sel_code = code_reg;
        endcase
    end

    // x on even bits, y on odd bits
    for (genvar i = 0; i < COORD_BITS; i++)
    begin : g_split
        assign coord_x[i] = sel_code[2*i];
        assign coord_y[i] = sel_code[2*i+1];
    end

    // shared grid compare
    assign grid_hit = (CMP_W'(coord_x) < CMP_W'(gw_reg)) &&
                      (CMP_W'(coord_y) < CMP_W'(gh_reg));

    assign p_last    = p_reg == P_W'(CODE_BITS - 1);
    assign quota_met = issued_reg >= cfg.total_tiles;
    assign end_now   = check_end_reg && all_done_reg && done_ok_reg;
    assign prod_full = PROD_W'(coord_y) * PROD_W'(gw_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_action == ACTION_START)
                        state_next = S_STATUS;
                    else if (running_reg || pending_reg)
                        state_next = S_SCAN;
                    else
                        state_next = S_STATUS;
                end
            end
            S_DIVW_GO:  state_next = S_DIVW_RUN;
            S_DIVW_RUN: state_next = div_done ? S_DIVH_GO : S_DIVW_RUN;
            S_DIVH_GO:  state_next = S_DIVH_RUN;
            S_DIVH_RUN: state_next = div_done ? S_IDLE : S_DIVH_RUN;
            S_SCAN:
            begin
                if (free_reg == '0 || quota_met)
                    state_next = S_STATUS;
                else if (free_reg[0])
                    state_next = S_CHECK;
            end
            S_CHECK:    state_next = grid_hit ? S_MUL : S_SEARCH;
            S_SEARCH:
            begin
                if ((!counter_reg[p_reg] && grid_hit) || p_last)
                    state_next = S_MUL;
            end
            S_MUL:      state_next = S_EMIT;
            S_EMIT:     state_next = word_ready ? S_SCAN : S_EMIT;
            S_STATUS:   state_next = word_ready ? S_IDLE : S_STATUS;
            default:    state_next = S_IDLE;
        endcase
        if (cfg_wr)
            state_next = S_DIVW_GO;
    end

    // datapath
    always_comb
    begin
        pending_next   = pending_reg;
        running_next   = running_reg;
        issued_next    = issued_reg;
        counter_next   = counter_reg;
        check_end_next = check_end_reg;
        all_done_next  = all_done_reg;
        done_ok_next   = done_ok_reg;
        free_next      = free_reg;
        idx_next       = idx_reg;
        p_next         = p_reg;
        code_next      = code_reg;
        prod_next      = prod_reg;
        gw_next        = gw_reg;
        gh_next        = gh_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    check_end_next = 1'b0;
                    all_done_next  = quota_met;
                    done_ok_next   = &(in_done | ~NS_MASK);
                    free_next      = in_free & NS_MASK;
                    idx_next       = '0;
                    if (in_action == ACTION_START)
                        pending_next = 1'b1;
                    else if (!running_reg)
                    begin
                        if (pending_reg)
                        begin
                            pending_next = 1'b0;
                            issued_next  = '0;
                            running_next = 1'b1;
                        end
                    end
                    else
                        check_end_next = 1'b1;
                end
            end
            S_DIVW_RUN:
            begin
                if (div_done)
                    gw_next = grid_dim;
            end
            S_DIVH_RUN:
            begin
                if (div_done)
                    gh_next = grid_dim;
            end
            S_SCAN:
            begin
                if (free_reg != '0 && !quota_met && !free_reg[0])
                begin
                    free_next = free_reg >> 1;
                    idx_next  = idx_reg + SIDX_W'(1);
                end
            end
            S_CHECK:
            begin
                code_next = counter_reg;
                p_next    = '0;
            end
            S_SEARCH:
            begin
                if (!counter_reg[p_reg] && grid_hit)
                    code_next = cand;
                else if (p_last)
                    code_next = '0;
                else
                    p_next = p_reg + P_W'(1);
            end
            S_MUL:
                prod_next = TILE_W'(prod_full);
            S_EMIT:
            begin
                if (word_ready)
                begin
                    counter_next = code_reg + CODE_BITS'(1);
                    issued_next  = issued_reg + TOTAL_W'(1);
                    free_next    = free_reg >> 1;
                    idx_next     = idx_reg + SIDX_W'(1);
                end
            end
            S_STATUS:
            begin
                if (word_ready && end_now)
                    running_next = 1'b0;
            end
            default:
            begin
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready   = state_reg == S_IDLE;
        div_start  = (state_reg == S_DIVW_GO) || (state_reg == S_DIVH_GO);
        word_valid = (state_reg == S_EMIT) || (state_reg == S_STATUS);
        if (state_reg == S_STATUS)
        begin
            word.kind         = KIND_STATUS;
            word.sorter_index = '0;
            word.tile_index   = '0;
            word.phase_busy   = pending_reg | (running_reg & ~end_now);
            word.last         = 1'b1;
        end
        else
        begin
            word.kind         = KIND_ASSIGN;
            word.sorter_index = idx_reg;
            word.tile_index   = prod_reg + TILE_W'(coord_x);
            word.phase_busy   = 1'b1;
            word.last         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_DIVW_GO;
            pending_reg   <= 1'b0;
            running_reg   <= 1'b0;
            issued_reg    <= '0;
            counter_reg   <= '0;
            check_end_reg <= 1'b0;
            all_done_reg  <= 1'b0;
            done_ok_reg   <= 1'b0;
            free_reg      <= '0;
            idx_reg       <= '0;
            p_reg         <= '0;
            gw_reg        <= GRID_W'(1);
            gh_reg        <= GRID_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            running_reg   <= running_next;
            issued_reg    <= issued_next;
            counter_reg   <= counter_next;
            check_end_reg <= check_end_next;
            all_done_reg  <= all_done_next;
            done_ok_reg   <= done_ok_next;
            free_reg      <= free_next;
            idx_reg       <= idx_next;
            p_reg         <= p_next;
            gw_reg        <= gw_next;
            gh_reg        <= gh_next;
        end
    end

    always_ff @(posedge clk)
    begin
        code_reg <= code_next;
        prod_reg <= prod_next;
    end

endmodule

// ----- design/morton_tile_dispatcher.sv -----
// Morton-order tile dispatcher. Each input word is either a start request
// or a tick carrying the free and done bits of the sorters; it yields one
// assignment word per tile handed out (sorters taken in index order) and
// then one status word with last set. Words are worked one at a time by a
// sequencer around a single grid-compare unit: a tick that works a phase
// steps past each non-free sorter, and each assignment passes through
// scan, grid check, multiply and emit, plus a search step per bit position
// tried when the Morton counter lies outside the grid, up to 2*COORD_BITS.
// The grid size is found by a bit-serial divider after reset and after
// every register write, during which in_ready stays low. A stall on the
// output holds the sequencer in its emit or status state.
module morton_tile_dispatcher #(
    parameter int SORTERS    = mtd_pkg::SORTERS_DEF,
    parameter int COORD_BITS = mtd_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [mtd_pkg::ADDR_W-1:0]   paddr,
    input  logic [mtd_pkg::DATA_W-1:0]   pwdata,
    output logic [mtd_pkg::DATA_W-1:0]   prdata,
    output logic                         pready,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         action,
    input  logic [mtd_pkg::IN_BITS-1:0]  sorter_free,
    input  logic [mtd_pkg::IN_BITS-1:0]  sorter_done,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         kind,
    output logic [mtd_pkg::SIDX_W-1:0]   sorter_index,
    output logic [mtd_pkg::TILE_W-1:0]   tile_index,
    output logic                         phase_busy,
    output logic                         last
);
    import mtd_pkg::*;

    cfg_t      cfg_reg, cfg_next;
    logic      cfg_wr;
    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg, out_word_next;
    out_word_t word;
    logic      word_valid;
    logic      word_ready;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_FRAME_WIDTH:  cfg_next.frame_width  = pwdata[FW_W-1:0];
                REG_FRAME_HEIGHT: cfg_next.frame_height = pwdata[FH_W-1:0];
                REG_TILE_EDGE:    cfg_next.tile_edge    = pwdata[EDGE_W-1:0];
                REG_TOTAL_TILES:  cfg_next.total_tiles  = pwdata[TOTAL_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_FRAME_WIDTH:  prdata = DATA_W'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT: prdata = DATA_W'(cfg_reg.frame_height);
            REG_TILE_EDGE:    prdata = DATA_W'(cfg_reg.tile_edge);
            REG_TOTAL_TILES:  prdata = DATA_W'(cfg_reg.total_tiles);
            default:          prdata = '0;
        endcase
    end

    mtd_core #(
        .SORTERS    (SORTERS),
        .COORD_BITS (COORD_BITS)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .cfg_wr     (cfg_wr),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_action  (action),
        .in_free    (sorter_free),
        .in_done    (sorter_done),
        .word_valid (word_valid),
        .word_ready (word_ready),
        .word       (word)
    );

    // output register
    assign word_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_word_next  = out_word_reg;
        if (word_ready)
        begin
            out_valid_next = word_valid;
            out_word_next  = word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.frame_width  <= FRAME_WIDTH_RST;
            cfg_reg.frame_height <= FRAME_HEIGHT_RST;
            cfg_reg.tile_edge    <= TILE_EDGE_RST;
            cfg_reg.total_tiles  <= TOTAL_TILES_RST;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

    assign out_valid    = out_valid_reg;
    assign kind         = out_word_reg.kind;
    assign sorter_index = out_word_reg.sorter_index;
    assign tile_index   = out_word_reg.tile_index;
    assign phase_busy   = out_word_reg.phase_busy;
    assign last         = out_word_reg.last;

`ifndef ASSERT_OFF
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_STATUS) == last)
        else $error("status word and last flag disagree");

    a_assign_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_ASSIGN |-> phase_busy)
        else $error("tile assigned outside a phase");

    a_one_word_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while previous word still in work");

    a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !word_valid)
        else $error("core offers a word while idle");
`endif

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import mtd_pkg::*;

    localparam int CB           = COORD_BITS_DEF;
    localparam int CODE_W       = 2 * CB;
    localparam int QUIET_LIMIT  = 3000;
    localparam int HOLD_AT      = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int TARGET_WORDS = 210;

    typedef struct {
        logic               act;
        logic [IN_BITS-1:0] free;
        logic [IN_BITS-1:0] done;
    } sorter_req_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                action = ACTION_TICK;
    logic [IN_BITS-1:0]  sorter_free = '0;
    logic [IN_BITS-1:0]  sorter_done = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic                kind;
    logic [SIDX_W-1:0]   sorter_index;
    logic [TILE_W-1:0]   tile_index;
    logic                phase_busy;
    logic                last;

    morton_tile_dispatcher u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .action       (action),
        .sorter_free  (sorter_free),
        .sorter_done  (sorter_done),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .sorter_index (sorter_index),
        .tile_index   (tile_index),
        .phase_busy   (phase_busy),
        .last         (last)
    );

    always #5 clk = ~clk;

    // mirror of the dispatcher: registers and phase state
    logic [FW_W-1:0]    cfg_fw;
    logic [FH_W-1:0]    cfg_fh;
    logic [EDGE_W-1:0]  cfg_tile_px;
    logic [TOTAL_W-1:0] cfg_total;
    logic               arm_pending;
    logic               running;
    logic [TOTAL_W-1:0] issued;
    logic [CODE_W-1:0]  zcount;

    sorter_req_t tick_feed[$];
    out_word_t   dispatch_words[$];

    int  queued = 0;
    int  in_count = 0;
    int  errors = 0;
    int  quiet = 0;
    int  send_gap = 0;
    int  stall = 0;
    int  hold_left = 0;
    bit  held = 1'b0;
    bit  calm = 1'b0;
    bit  in_took = 1'b0;
    sorter_req_t nxt;
    out_word_t   want;

    function automatic logic [CB-1:0] coord_of(logic [CODE_W-1:0] code, int sel);
        logic [CB-1:0] r;
        for (int i = 0; i < CB; i++)
            r[i] = code[2*i + sel];
        return r;
    endfunction

    function automatic bit fits_grid(logic [CODE_W-1:0] code, int unsigned gw,
                                     int unsigned gh);
        return coord_of(code, 0) < gw && coord_of(code, 1) < gh;
    endfunction

    // smallest Morton code at or above c inside the grid, else wrap to 0
    function automatic logic [CODE_W-1:0] next_in_grid(logic [CODE_W-1:0] c,
                                                      int unsigned gw, int unsigned gh);
        logic [CODE_W-1:0] cand;
        if (fits_grid(c, gw, gh))
            return c;
        for (int p = 0; p < CODE_W; p++) begin
            if (!c[p]) begin
                cand = c & ({CODE_W{1'b1}} << p);
                cand[p] = 1'b1;
                if (fits_grid(cand, gw, gh))
                    return cand;
            end
        end
        return '0;
    endfunction

    function automatic void reset_model();
        cfg_fw      = FRAME_WIDTH_RST;
        cfg_fh      = FRAME_HEIGHT_RST;
        cfg_tile_px = TILE_EDGE_RST;
        cfg_total   = TOTAL_TILES_RST;
        arm_pending = 1'b0;
        running     = 1'b0;
        issued      = '0;
        zcount      = '0;
    endfunction

    function automatic void dispatch_step(logic act, logic [IN_BITS-1:0] free,
                                          logic [IN_BITS-1:0] done);
        bit                do_assign;
        bit                check_end;
        bit                all_issued;
        int unsigned       e;
        int unsigned       gw;
        int unsigned       gh;
        logic [CODE_W-1:0] code;
        longint unsigned   tile;
        out_word_t         w;
        do_assign  = 1'b0;
        check_end  = 1'b0;
        all_issued = 1'b0;
        if (act == ACTION_START) begin
            arm_pending = 1'b1;
        end else if (!running) begin
            if (arm_pending) begin
                arm_pending = 1'b0;
                issued      = '0;
                running     = 1'b1;
                do_assign   = 1'b1;
            end
        end else begin
            all_issued = issued >= cfg_total;
            do_assign  = 1'b1;
            check_end  = 1'b1;
        end
        if (do_assign) begin
            e  = (cfg_tile_px == 0) ? 1 : cfg_tile_px;
            gw = (cfg_fw + e - 1) / e;
            gh = (cfg_fh + e - 1) / e;
            if (gw == 0)
                gw = 1;
            if (gh == 0)
                gh = 1;
            for (int i = 0; i < IN_BITS; i++) begin
                if (issued < cfg_total && free[i]) begin
                    code = next_in_grid(zcount, gw, gh);
                    tile = coord_of(code, 1);
                    tile = tile * gw + coord_of(code, 0);
                    zcount = code + 1'b1;
                    issued = issued + 1'b1;
                    w.kind         = KIND_ASSIGN;
                    w.sorter_index = SIDX_W'(i);
                    w.tile_index   = tile[TILE_W-1:0];
                    w.phase_busy   = 1'b1;
                    w.last         = 1'b0;
                    dispatch_words.push_back(w);
                end
            end
        end
        if (check_end) begin
            if (done != {IN_BITS{1'b1}})
                all_issued = 1'b0;
            if (all_issued)
                running = 1'b0;
        end
        w.kind         = KIND_STATUS;
        w.sorter_index = '0;
        w.tile_index   = '0;
        w.phase_busy   = arm_pending | running;
        w.last         = 1'b1;
        dispatch_words.push_back(w);
    endfunction

    // input side: take accepted words into the mirror
    always @(posedge clk) begin
        in_took = rst_n && in_valid && in_ready;
        if (in_took) begin
            dispatch_step(action, sorter_free, sorter_done);
            in_count++;
        end
    end

    // output side: compare each word with the oldest expectation
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (dispatch_words.size() == 0) begin
                $error("unexpected word: kind %0d sorter %0d tile %0d", kind,
                       sorter_index, tile_index);
                errors++;
            end else begin
                want = dispatch_words.pop_front();
                if (kind !== want.kind) begin
                    $error("kind: expected %0d, actual %0d", want.kind, kind);
                    errors++;
                end
                if (sorter_index !== want.sorter_index) begin
                    $error("sorter_index: expected %0d, actual %0d", want.sorter_index,
                           sorter_index);
                    errors++;
                end
                if (tile_index !== want.tile_index) begin
                    $error("tile_index: expected %0d, actual %0d", want.tile_index,
                           tile_index);
                    errors++;
                end
                if (phase_busy !== want.phase_busy) begin
                    $error("phase_busy: expected %0d, actual %0d", want.phase_busy,
                           phase_busy);
                    errors++;
                end
                if (last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, last);
                    errors++;
                end
            end
        end
    end

    // sender
    always @(negedge clk) begin
        if (!in_valid || in_took) begin
            if (send_gap > 0) begin
                send_gap--;
                in_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                send_gap = $urandom_range(0, 5);
                in_valid <= 1'b0;
            end else if (tick_feed.size() > 0) begin
                nxt = tick_feed.pop_front();
                in_valid    <= 1'b1;
                action      <= nxt.act;
                sorter_free <= nxt.free;
                sorter_done <= nxt.done;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // receiver; one long hold-off early on to back the block up
    always @(negedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (!held && in_count >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            out_ready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
            stall = $urandom_range(0, 5);
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (psel && penable && pwrite && pready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("tb_top: errors");
                $finish;
            end
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_FRAME_WIDTH:  cfg_fw      = val[FW_W-1:0];
            REG_FRAME_HEIGHT: cfg_fh      = val[FH_W-1:0];
            REG_TILE_EDGE:    cfg_tile_px = val[EDGE_W-1:0];
            REG_TOTAL_TILES:  cfg_total   = val[TOTAL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input int unsigned fw, input int unsigned fh,
                              input int unsigned px, input int unsigned total);
        write_reg(REG_FRAME_WIDTH, fw);
        write_reg(REG_FRAME_HEIGHT, fh);
        write_reg(REG_TILE_EDGE, px);
        write_reg(REG_TOTAL_TILES, total);
    endtask

    // idle: nothing queued, nothing offered, nothing outstanding
    task automatic wait_idle();
        while (tick_feed.size() != 0 || in_valid || dispatch_words.size() != 0)
            @(posedge clk);
    endtask

    function automatic void queue_word(logic act, logic [IN_BITS-1:0] free,
                                       logic [IN_BITS-1:0] done);
        sorter_req_t r;
        r.act  = act;
        r.free = free;
        r.done = done;
        tick_feed.push_back(r);
        queued++;
    endfunction

    function automatic logic [IN_BITS-1:0] pick_free();
        return ($urandom_range(0, 2) != 0) ? {IN_BITS{1'b1}} : IN_BITS'($urandom);
    endfunction

    // start, ticks until the tile budget is handed out, then a closing tick
    task automatic fill_phase(input int unsigned goal, input bit stray_starts);
        int unsigned         given;
        logic [IN_BITS-1:0]  f;
        given = 0;
        queue_word(ACTION_START, IN_BITS'($urandom), IN_BITS'($urandom));
        while (given < goal) begin
            f = pick_free();
            if (stray_starts && $urandom_range(0, 15) == 0)
                queue_word(ACTION_START, IN_BITS'($urandom), IN_BITS'($urandom));
            queue_word(ACTION_TICK, f, IN_BITS'($urandom));
            given += $countones(f);
        end
        queue_word(ACTION_TICK, pick_free(), {IN_BITS{1'b1}});
    endtask

    task automatic random_phase();
        wait_idle();
        case ($urandom_range(0, 5))
            0: set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 511), $urandom_range(0, 24));
            1: set_config(65535, $urandom_range(1, 8), 1, $urandom_range(1, 24));
            2: set_config($urandom_range(1, 8), 65535, 1, $urandom_range(1, 24));
            default: set_config($urandom_range(1, 300), $urandom_range(1, 300),
                                $urandom_range(1, 64), $urandom_range(0, 30));
        endcase
        if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(3, 8))
                queue_word(1'($urandom), IN_BITS'($urandom), IN_BITS'($urandom));
        end else begin
            fill_phase(cfg_total, 1'b1);
        end
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset registers, no tiles: tick with no phase, double start, empty phase
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        queue_word(ACTION_START, 4'h0, 4'h0);
        queue_word(ACTION_START, 4'hF, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'h0);
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        wait_idle();

        // zero edge and zero frame: 1x1 grid, counter keeps wrapping to 0
        set_config(0, 0, 0, 6);
        queue_word(ACTION_START, 4'h0, 4'h0);
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        queue_word(ACTION_START, 4'h5, 4'hA);
        queue_word(ACTION_TICK, 4'b1010, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'b0111);
        queue_word(ACTION_TICK, 4'h0, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'h0);
        queue_word(ACTION_TICK, 4'h3, 4'hF);
        queue_word(ACTION_TICK, 4'h0, 4'hF);
        wait_idle();

        // largest frame, edge of 256, budget at the top of the register
        set_config(65535, 65535, 256, 32'h01FF_FFFF);
        queue_word(ACTION_START, 4'hF, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'h0);
        queue_word(ACTION_TICK, 4'b0110, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        wait_idle();
        write_reg(REG_TOTAL_TILES, 5);
        queue_word(ACTION_TICK, 4'h0, 4'hF);
        wait_idle();

        // rows wider than the coordinate range
        set_config(65535, 3, 1, 8);
        queue_word(ACTION_START, 4'h0, 4'h0);
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        queue_word(ACTION_TICK, 4'hF, 4'hF);
        queue_word(ACTION_TICK, 4'h0, 4'hF);
        wait_idle();

        // single column: walk y past 256 so the next wide grid overflows 24 bits
        set_config(1, 65535, 1, 280);
        fill_phase(280, 1'b0);
        wait_idle();
        set_config(65535, 65535, 1, 20);
        fill_phase(20, 1'b0);

        while (queued < TARGET_WORDS - 25)
            random_phase();
        wait_idle();
        calm = 1'b1;
        random_phase();
        random_phase();

        wait_idle();
        repeat (60) @(posedge clk);
        if (dispatch_words.size() != 0)
            $error("%0d expected words never arrived", dispatch_words.size());
        if (errors == 0 && dispatch_words.size() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
